// ===== rtl/gppe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gppe_pkg
// Shared types and constants of the grb pixel pulse encoder.
// ----------------------------------------------------------------------------
package gppe_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int LEVEL_W        = 8;
    localparam int DUR_W          = 10;
    localparam int BIT_CNT_W      = 5;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 32;
    localparam int S_TDATA_W      = 24;
    localparam int M_TDATA_W      = 24;
    localparam int PULSE_W        = 1 + 2 * DUR_W;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_PIXEL - 1);

    localparam logic [DUR_W-1:0] ZERO_HIGH_RST = DUR_W'(6);
    localparam logic [DUR_W-1:0] ZERO_LOW_RST  = DUR_W'(14);
    localparam logic [DUR_W-1:0] ONE_HIGH_RST  = DUR_W'(13);
    localparam logic [DUR_W-1:0] ONE_LOW_RST   = DUR_W'(7);

    typedef enum logic [1:0] {
        REG_ZERO_HIGH = 2'd0,
        REG_ZERO_LOW  = 2'd1,
        REG_ONE_HIGH  = 2'd2,
        REG_ONE_LOW   = 2'd3
    } gppe_reg_idx_t;

    typedef logic [BITS_PER_PIXEL-1:0] gppe_word_t;

    typedef struct packed {
        logic [DUR_W-1:0] zero_high;
        logic [DUR_W-1:0] zero_low;
        logic [DUR_W-1:0] one_high;
        logic [DUR_W-1:0] one_low;
    } gppe_timing_t;

    typedef struct packed {
        logic             pixel_done;
        logic [DUR_W-1:0] low_time;
        logic [DUR_W-1:0] high_time;
        logic             coded_bit;
    } gppe_pulse_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } gppe_hs_t;

endpackage
`default_nettype wire

// ===== rtl/gppe_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gppe_front
// Input stage: takes pixel beats, orders the bytes for msb-first serial
// output and holds one pixel word for the queue.
// ----------------------------------------------------------------------------
module gppe_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [gppe_pkg::S_TDATA_W-1:0] s_tdata,
    output gppe_pkg::gppe_hs_t                push_hs,
    input  wire logic                         push_ready,
    output gppe_pkg::gppe_word_t              push_word
);
    import gppe_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    gppe_word_t word_reg;
    logic       accept;

    assign s_tready = !valid_reg || push_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // green goes out first, so it sits in the top byte
    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg <= {s_tdata[LEVEL_W-1:0],
                         s_tdata[2*LEVEL_W-1:LEVEL_W],
                         s_tdata[3*LEVEL_W-1:2*LEVEL_W]};
        end
    end

    assign push_hs.valid = valid_reg;
    assign push_hs.ready = push_ready;
    assign push_word     = word_reg;

endmodule
`default_nettype wire

// ===== rtl/gppe_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gppe_queue
// Short pixel word queue between the input stage and the serializer.
// ----------------------------------------------------------------------------
module gppe_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire gppe_pkg::gppe_hs_t   push_hs,
    input  wire gppe_pkg::gppe_word_t push_word,
    output logic                      push_ready,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output gppe_pkg::gppe_word_t      pop_word,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import gppe_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    gppe_word_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_hs.valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = mem[rd_ptr_reg];
    assign count      = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gppe_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gppe_back
// Serializer: shifts a pixel word out msb first, one pulse beat per cycle
// while m_tready allows, and looks up the high and low durations for each bit.
// ----------------------------------------------------------------------------
module gppe_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   pop_valid,
    output logic                        pop_ready,
    input  wire gppe_pkg::gppe_word_t   pop_word,
    input  wire gppe_pkg::gppe_timing_t timing,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output gppe_pkg::gppe_pulse_t       pulse
);
    import gppe_pkg::*;

    gppe_word_t           word_reg;
    gppe_word_t           word_next;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic [BIT_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    gppe_pulse_t          pulse_reg;
    gppe_pulse_t          pulse_next;
    logic                 out_free;
    logic                 at_last;
    logic                 emit;
    logic                 load;
    logic                 bit_now;

    assign out_free  = !out_valid_reg || m_tready;
    assign at_last   = (cnt_reg == LAST_BIT);
    assign emit      = out_free && busy_reg;
    assign pop_ready = out_free && (!busy_reg || at_last);
    assign load      = pop_ready && pop_valid;
    assign bit_now   = word_reg[BITS_PER_PIXEL-1];

    always_comb begin
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        pulse_next     = pulse_reg;
        if (emit) begin
            out_valid_next       = 1'b1;
            pulse_next.coded_bit = bit_now;
            pulse_next.high_time = bit_now ? timing.one_high : timing.zero_high;
            pulse_next.low_time  = bit_now ? timing.one_low : timing.zero_low;
            pulse_next.pixel_done = at_last;
            word_next            = {word_reg[BITS_PER_PIXEL-2:0], 1'b0};
            cnt_next             = cnt_reg + BIT_CNT_W'(1);
            if (at_last) begin
                busy_next = 1'b0;
            end
        end else if (out_free) begin
            out_valid_next = 1'b0;
        end
        if (load) begin
            word_next = pop_word;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        pulse_reg <= pulse_next;
    end

    assign m_tvalid = out_valid_reg;
    assign pulse    = pulse_reg;

endmodule
`default_nettype wire

// ===== rtl/grb_pixel_pulse_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grb_pixel_pulse_encoder
// Turns green, red, blue pixel beats into per-bit pulse timing beats for a
// one-wire led strip, with apb-programmable zero and one bit timings.
//
// channel  dir  payload
// s_*      in   tdata[7:0] green, [15:8] red, [23:16] blue
// m_*      out  tdata[0] bit, [10:1] high time, [20:11] low time; tlast = pixel done
// apb      in   0x0 zero high, 0x4 zero low, 0x8 one high, 0xc one low
//
// each pixel yields 24 beats, one per cycle while m_tready is high; the
// serializer shift register sets that rate and the next pixel follows with
// no gap. each input beat passes input register, queue, shifter and pulse register.
// input and output stall independently through a pixel queue of QUEUE_DEPTH.
// reset restores the default timings and empties every stage.
// ----------------------------------------------------------------------------
module grb_pixel_pulse_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // green [7:0], red [15:8], blue [23:16]
    input  wire logic [gppe_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // coded_bit [0], high_time [10:1], low_time [20:11], zero [23:21]
    output logic [gppe_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gppe_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [gppe_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gppe_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import gppe_pkg::*;

    gppe_timing_t               timing_reg;
    gppe_timing_t               timing_next;
    gppe_reg_idx_t              reg_idx;
    logic                       wr_en;
    logic [DUR_W-1:0]           rd_val;

    gppe_hs_t                   push_hs;
    logic                       push_ready;
    gppe_word_t                 push_word;
    logic                       pop_valid;
    logic                       pop_ready;
    gppe_word_t                 pop_word;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    gppe_pulse_t                pulse;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = gppe_reg_idx_t'(paddr[3:2]);

    always_comb begin
        timing_next = timing_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_ZERO_HIGH: timing_next.zero_high = pwdata[DUR_W-1:0];
                REG_ZERO_LOW:  timing_next.zero_low  = pwdata[DUR_W-1:0];
                REG_ONE_HIGH:  timing_next.one_high  = pwdata[DUR_W-1:0];
                REG_ONE_LOW:   timing_next.one_low   = pwdata[DUR_W-1:0];
                default:       timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.zero_high <= ZERO_HIGH_RST;
            timing_reg.zero_low  <= ZERO_LOW_RST;
            timing_reg.one_high  <= ONE_HIGH_RST;
            timing_reg.one_low   <= ONE_LOW_RST;
        end else begin
            timing_reg <= timing_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ZERO_HIGH: rd_val = timing_reg.zero_high;
            REG_ZERO_LOW:  rd_val = timing_reg.zero_low;
            REG_ONE_HIGH:  rd_val = timing_reg.one_high;
            REG_ONE_LOW:   rd_val = timing_reg.one_low;
            default:       rd_val = '0;
        endcase
    end

    assign prdata = APB_DATA_W'(rd_val);

    gppe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_hs    (push_hs),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    gppe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_hs    (push_hs),
        .push_word  (push_word),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word),
        .count      (q_count)
    );

    gppe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_word  (pop_word),
        .timing    (timing_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .pulse     (pulse)
    );

    assign m_tdata = M_TDATA_W'(PULSE_W'({pulse.low_time, pulse.high_time, pulse.coded_bit}));
    assign m_tlast = pulse.pixel_done;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("pixel queue count above depth");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (push_hs.valid && !push_ready))
        else $error("input stalled while queue has room");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready) |-> (q_count != '0))
        else $error("serializer took a word from an empty queue");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("pulse beat changed while stalled");

endmodule
`default_nettype wire

// ===== dv/pulse_timing_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pulse_timing_checker
// Watches the pixel, pulse and apb channels of the grb pixel pulse encoder.
// Keeps its own copy of the four bit timings, expands every accepted pixel
// into its 24 expected pulses (green, red, blue, msb first) and compares
// each pulse beat in order with the oldest expected pulse.
// ----------------------------------------------------------------------------
module pulse_timing_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // green [7:0], red [15:8], blue [23:16]
    input  wire logic [gppe_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    // coded_bit [0], high_time [10:1], low_time [20:11], zero [23:21]
    input  wire logic [gppe_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                            m_tlast,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gppe_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [gppe_pkg::APB_DATA_W-1:0] pwdata,
    input  wire logic                            pready,
    output int                                   pending,
    output int                                   fail_count
);
    import gppe_pkg::*;

    gppe_timing_t timing;
    gppe_pulse_t  pulse_q[$];
    int           err_total = 0;

    always @(posedge aclk) begin : track
        gppe_pulse_t exp_p;
        gppe_pulse_t got_p;
        logic        bit_val;
        int          pos;
        if (!aresetn) begin
            timing.zero_high = ZERO_HIGH_RST;
            timing.zero_low  = ZERO_LOW_RST;
            timing.one_high  = ONE_HIGH_RST;
            timing.one_low   = ONE_LOW_RST;
            pulse_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (gppe_reg_idx_t'(paddr[3:2]))
                    REG_ZERO_HIGH: timing.zero_high = pwdata[DUR_W-1:0];
                    REG_ZERO_LOW:  timing.zero_low  = pwdata[DUR_W-1:0];
                    REG_ONE_HIGH:  timing.one_high  = pwdata[DUR_W-1:0];
                    REG_ONE_LOW:   timing.one_low   = pwdata[DUR_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got_p.coded_bit  = m_tdata[0];
                got_p.high_time  = m_tdata[DUR_W:1];
                got_p.low_time   = m_tdata[2*DUR_W:DUR_W+1];
                got_p.pixel_done = m_tlast;
                if (pulse_q.size() == 0) begin
                    $display("%0t: unexpected pulse beat, actual bit %0d high %0d low %0d last %0d",
                             $time, got_p.coded_bit, got_p.high_time, got_p.low_time,
                             got_p.pixel_done);
                    err_total++;
                end else begin
                    exp_p = pulse_q.pop_front();
                    if (got_p != exp_p) begin
                        $display("%0t: pulse mismatch, expected bit %0d high %0d low %0d last %0d",
                                 $time, exp_p.coded_bit, exp_p.high_time, exp_p.low_time,
                                 exp_p.pixel_done);
                        $display("%0t:                 actual   bit %0d high %0d low %0d last %0d",
                                 $time, got_p.coded_bit, got_p.high_time, got_p.low_time,
                                 got_p.pixel_done);
                        err_total++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                for (int n = 0; n < BITS_PER_PIXEL; n++) begin
                    // byte by byte, msb first
                    pos     = (n / LEVEL_W) * LEVEL_W + (LEVEL_W - 1 - n % LEVEL_W);
                    bit_val = s_tdata[pos];
                    exp_p.coded_bit  = bit_val;
                    exp_p.high_time  = bit_val ? timing.one_high : timing.zero_high;
                    exp_p.low_time   = bit_val ? timing.one_low : timing.zero_low;
                    exp_p.pixel_done = (n == BITS_PER_PIXEL - 1);
                    pulse_q.push_back(exp_p);
                end
            end
        end
        pending    <= pulse_q.size();
        fail_count <= err_total;
    end

endmodule

// ===== dv/grb_pixel_pulse_encoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grb_pixel_pulse_encoder_test
// Drives pixels and apb timing writes into the grb pixel pulse encoder under
// several timing settings (reset, all max, all 1, zero, mixed, random) and
// several idle patterns on both stream sides; a separate checker predicts
// and compares every pulse beat.
// ----------------------------------------------------------------------------
module grb_pixel_pulse_encoder_test;
    import gppe_pkg::*;

    localparam int IDLE_LIMIT       = 4000;
    localparam int PHASES           = 8;
    localparam int PIXELS_PER_PHASE = 46;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int pending;
    int fail_count;
    int quiet_cycles = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    always #5ns aclk = ~aclk;

    grb_pixel_pulse_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pulse_timing_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic drive_pixel(input gppe_word_t w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_timing(input gppe_reg_idx_t idx, input logic [DUR_W-1:0] v);
        logic [APB_DATA_W-1:0] word;
        word = $urandom();
        word[DUR_W-1:0] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_all(input logic [DUR_W-1:0] zh, input logic [DUR_W-1:0] zl,
                             input logic [DUR_W-1:0] oh, input logic [DUR_W-1:0] ol);
        write_timing(REG_ZERO_HIGH, zh);
        write_timing(REG_ZERO_LOW, zl);
        write_timing(REG_ONE_HIGH, oh);
        write_timing(REG_ONE_LOW, ol);
    endtask

    // drain every expected pulse, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [LEVEL_W-1:0] random_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return LEVEL_W'($urandom());
        endcase
    endfunction

    initial begin
        gppe_word_t directed[$];
        directed = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                     24'h808080, 24'h010101, 24'hAAAAAA, 24'h555555, 24'h800001,
                     24'h123456, 24'hFEDCBA, 24'h7F7F7F, 24'h0F0F0F, 24'hF0F0F0,
                     24'h000001};
        aresetn  <= 1'b0;
        s_tdata  <= '0;
        s_tvalid <= 1'b0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset timings
        foreach (directed[i]) drive_pixel(directed[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: write_all(10'd1023, 10'd1023, 10'd1023, 10'd1023);
                1: write_all(10'd1, 10'd1, 10'd1, 10'd1);
                2: write_all(10'd0, 10'd0, 10'd0, 10'd0);
                3: write_all(10'd1, 10'd1023, 10'd1023, 10'd1);
                default: write_all(DUR_W'($urandom_range(0, 1023)),
                                   DUR_W'($urandom_range(0, 1023)),
                                   DUR_W'($urandom_range(0, 1023)),
                                   DUR_W'($urandom_range(0, 1023)));
            endcase
            case (ph % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 49;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 49;
                end
                default: begin
                    src_idle_pct   = 15;
                    sink_stall_pct = 15;
                end
            endcase
            for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
                drive_pixel({random_level(), random_level(), random_level()});
            end
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gppe_pkg.sv
rtl/gppe_front.sv
rtl/gppe_queue.sv
rtl/gppe_back.sv
rtl/grb_pixel_pulse_encoder.sv
dv/pulse_timing_checker.sv
dv/grb_pixel_pulse_encoder_test.sv
